// ----- hw/rtl/efr_pkg.sv -----
// Package for the escaped frame receiver: link control codes, sizes,
// queue entry and result types, and the CRC-16 byte update. No dependencies.
`timescale 1ns / 1ps

package efr_pkg;

  localparam int BUFFER_BYTES = 256;
  localparam int CNT_W        = $clog2(BUFFER_BYTES - 1);
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(BUFFER_BYTES - 2);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_DLE = 8'h10;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_GOOD  = 2'd2;
  localparam logic [1:0] EV_BAD   = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_SOH  = 2'd1,
    OP_EOT  = 2'd2,
    OP_DATA = 2'd3
  } efr_op_e_t;

  typedef struct packed {
    efr_op_e_t  op;
    logic [7:0] data;
  } efr_op_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } efr_result_t;

  function automatic logic [15:0] nib_entry(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'h0: r = 16'h0000;
      4'h1: r = 16'h1021;
      4'h2: r = 16'h2042;
      4'h3: r = 16'h3063;
      4'h4: r = 16'h4084;
      4'h5: r = 16'h50a5;
      4'h6: r = 16'h60c6;
      4'h7: r = 16'h70e7;
      4'h8: r = 16'h8108;
      4'h9: r = 16'h9129;
      4'ha: r = 16'ha14a;
      4'hb: r = 16'hb16b;
      4'hc: r = 16'hc18c;
      4'hd: r = 16'hd1ad;
      4'he: r = 16'he1ce;
      default: r = 16'hf1ef;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = nib_entry(c[15:12] ^ b[7:4]) ^ {c[11:0], 4'h0};
    return nib_entry(t[15:12] ^ b[3:0]) ^ {t[11:0], 4'h0};
  endfunction

endpackage

// ----- hw/rtl/efr_if.sv -----
// Handshake channels of the escaped frame receiver: raw byte in, result out.
// Depends on nothing.
`timescale 1ns / 1ps

interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  frame_length;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output frame_length, output received_crc, output computed_crc,
                  input ready);
  modport sink (input valid, input event_res, input data_byte, input byte_index,
                input frame_length, input received_crc, input computed_crc,
                output ready);
endinterface

// ----- hw/rtl/escaped_frame_receiver_crc_check.sv -----
// Escaped frame receiver with CRC-16 check, top level.
// A byte's transaction writes the queue, the back end pops it from the queue head,
// and its result is registered and valid from then on.
// Throughput: one byte per cycle while the result side is ready; the back end's CRC
// byte update (two nibble table steps) and frame check are combinational per operation.
// Reset (rst, synchronous): clears escape flag, queue, count, CRC, delay line.
// Depends on efr_pkg, efr_if, efr_front, efr_queue, efr_back.
`timescale 1ns / 1ps

module escaped_frame_receiver_crc_check import efr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  efr_in_if.sink    rx,
  efr_out_if.source res
);

  logic        push_valid;
  logic        push_ready;
  efr_op_t     push_entry;
  logic        pop_valid;
  logic        pop_ready;
  efr_op_t     pop_entry;
  efr_result_t out_result;

  efr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_byte    (rx.rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  efr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  efr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_result (out_result)
  );

  assign res.event_res    = out_result.event_res;
  assign res.data_byte    = out_result.data_byte;
  assign res.byte_index   = out_result.byte_index;
  assign res.frame_length = out_result.frame_length;
  assign res.received_crc = out_result.received_crc;
  assign res.computed_crc = out_result.computed_crc;

endmodule

// ----- hw/rtl/efr_front.sv -----
// Front end: takes raw link bytes, tracks the escape flag and classifies each
// byte into an operation for the queue. Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_front import efr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output efr_op_t    push_entry
);

  logic escape_pending;
  logic escape_pending_next;
  logic take;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  always_comb begin
    push_entry.data     = in_byte;
    push_entry.op       = OP_DATA;
    escape_pending_next = 1'b0;
    if (!escape_pending) begin
      case (in_byte)
        CH_SOH: push_entry.op = OP_SOH;
        CH_EOT: push_entry.op = OP_EOT;
        CH_DLE: begin
          push_entry.op       = OP_NOP;
          escape_pending_next = 1'b1;
        end
        default: push_entry.op = OP_DATA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (take) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ----- hw/rtl/efr_queue.sv -----
// Short queue of classified operations between front and back end.
// Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_queue import efr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  efr_op_t push_entry,
  output logic    pop_valid,
  input  logic    pop_ready,
  output efr_op_t pop_entry
);

  efr_op_t entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic push;
  logic pop;

  assign push_ready = fill != QCNT_W'(QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_entry  = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/efr_back.sv -----
// Back end: payload count, two-byte delay, running CRC and frame check;
// registers one result per operation. Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_back import efr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  efr_op_t     pop_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output efr_result_t out_result
);

  logic [CNT_W-1:0] payload_count;
  logic [CNT_W-1:0] payload_count_next;
  logic [15:0]      running_crc;
  logic [15:0]      running_crc_next;
  logic [7:0]       newest_byte;
  logic [7:0]       newest_byte_next;
  logic [7:0]       older_byte;
  logic [7:0]       older_byte_next;
  logic [CNT_W-1:0] cnt_eff;
  logic [15:0]      crc_eff;
  logic [15:0]      rx_crc;
  efr_result_t      result;
  logic             pop;

  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign rx_crc    = {newest_byte, older_byte};

  always_comb begin
    cnt_eff = payload_count;
    crc_eff = running_crc;
    if (payload_count >= COUNT_LIMIT) begin
      cnt_eff = '0;
      crc_eff = '0;
    end
    payload_count_next = cnt_eff;
    running_crc_next   = crc_eff;
    newest_byte_next   = newest_byte;
    older_byte_next    = older_byte;
    result             = '0;
    case (pop_entry.op)
      OP_DATA: begin
        if (cnt_eff >= CNT_W'(2)) begin
          running_crc_next = crc_byte(crc_eff, older_byte);
        end
        older_byte_next    = newest_byte;
        newest_byte_next   = pop_entry.data;
        payload_count_next = cnt_eff + 1'b1;
        result.event_res   = EV_BYTE;
        result.data_byte   = pop_entry.data;
        result.byte_index  = 8'(cnt_eff);
      end
      OP_SOH: begin
        payload_count_next = '0;
        running_crc_next   = '0;
      end
      OP_EOT: begin
        if (cnt_eff > CNT_W'(1)) begin
          if (rx_crc != crc_eff || cnt_eff > CNT_W'(2)) begin
            result.event_res    = (rx_crc == crc_eff) ? EV_GOOD : EV_BAD;
            result.frame_length = 8'(cnt_eff);
            result.received_crc = rx_crc;
            result.computed_crc = crc_eff;
          end
        end
      end
      default: begin
        result.event_res = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= '0;
      running_crc   <= '0;
      newest_byte   <= '0;
      older_byte    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        payload_count <= payload_count_next;
        running_crc   <= running_crc_next;
        newest_byte   <= newest_byte_next;
        older_byte    <= older_byte_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result;
    end
  end

endmodule

// ----- tb/escaped_frame_receiver_crc_check_test.sv -----
// Regression for escaped_frame_receiver_crc_check: stuffed link frames in, per-byte results out,
// each result checked against an in-bench unstuffer and CRC-16 frame checker.
// Depends on efr_pkg, efr_if and escaped_frame_receiver_crc_check from the RTL.
`timescale 1ns / 1ps

module escaped_frame_receiver_crc_check_test;
  import efr_pkg::*;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int          RANDOM_BYTES = 800;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          PRINT_LIMIT  = 40;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_COIN,
    SINK_THIRDS,
    SINK_MOSTLY
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  efr_in_if  rx_if ();
  efr_out_if res_if ();

  escaped_frame_receiver_crc_check uut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if.sink),
    .res(res_if.source)
  );

  always #2 clk = ~clk;

  // unstuffer state
  logic             link_escape;
  logic [CNT_W-1:0] link_count;
  logic [15:0]      link_crc;
  logic [7:0]       newest_rx;
  logic [7:0]       older_rx;

  efr_result_t expected_results[$];
  efr_result_t want;
  logic [7:0]  frame_body[$];

  int cycle_count = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int payload_seen = 0;
  int good_seen = 0;
  int bad_seen = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int sink_left = 0;
  sink_mode_t sink_mode = SINK_ALWAYS;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    int i;
    acc = c ^ {b, 8'h00};
    for (i = 0; i < 8; i++)
      acc = {acc[14:0], 1'b0} ^ (acc[15] ? CRC_POLY : 16'h0000);
    return acc;
  endfunction

  function automatic efr_result_t unstuff_byte(input logic [7:0] b);
    efr_result_t r;
    logic take;
    logic [15:0] carried;
    r = '0;
    take = 1'b0;
    if (link_count >= COUNT_LIMIT) begin
      link_count = '0;
      link_crc = '0;
    end
    if (link_escape) begin
      take = 1'b1;
    end else if (b == CH_SOH) begin
      link_count = '0;
      link_crc = '0;
    end else if (b == CH_DLE) begin
      link_escape = 1'b1;
    end else if (b == CH_EOT) begin
      if (link_count > 1) begin
        carried = {newest_rx, older_rx};
        if (carried != link_crc || link_count > 2) begin
          r.event_res = (carried == link_crc) ? EV_GOOD : EV_BAD;
          r.frame_length = 8'(link_count);
          r.received_crc = carried;
          r.computed_crc = link_crc;
        end
      end
    end else begin
      take = 1'b1;
    end
    if (take) begin
      link_escape = 1'b0;
      if (link_count >= 2)
        link_crc = crc16_update(link_crc, older_rx);
      older_rx = newest_rx;
      newest_rx = b;
      r.event_res = EV_BYTE;
      r.data_byte = b;
      r.byte_index = 8'(link_count);
      link_count = link_count + 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s: got %h, want %h", results_seen, name, got,
                                exp_val));
  endtask

  // predict on input transactions, then check output transactions
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        expected_results.push_back(unstuff_byte(rx_if.rx_byte));
        bytes_sent++;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, event %0d", res_if.event_res));
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", 16'(res_if.event_res), 16'(want.event_res));
          check_field("data_byte", 16'(res_if.data_byte), 16'(want.data_byte));
          check_field("byte_index", 16'(res_if.byte_index), 16'(want.byte_index));
          check_field("frame_length", 16'(res_if.frame_length), 16'(want.frame_length));
          check_field("received_crc", res_if.received_crc, want.received_crc);
          check_field("computed_crc", res_if.computed_crc, want.computed_crc);
          case (want.event_res)
            EV_BYTE: payload_seen++;
            EV_GOOD: good_seen++;
            EV_BAD:  bad_seen++;
            default: ;
          endcase
        end
        results_seen++;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 80);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_ALWAYS: res_if.ready <= 1'b1;
      SINK_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
      SINK_THIRDS: res_if.ready <= (cycle_count % 3 == 0);
      default:     res_if.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("escaped_frame_receiver_crc_check regression: fail");
    $finish;
  end

  function automatic logic [7:0] pick_link_byte();
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0:       b = CH_SOH;
        1:       b = CH_EOT;
        default: b = CH_DLE;
      endcase
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic int pick_body_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      return $urandom_range(240, 300);
    if (r < 12)
      return $urandom_range(25, 80);
    return $urandom_range(0, 24);
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
    if (burst_left == 0) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == CH_SOH || b == CH_EOT || b == CH_DLE || $urandom_range(0, 19) == 0)
      send_byte(CH_DLE);
    send_byte(b);
  endtask

  task automatic fill_random_body(input int n);
    frame_body.delete();
    repeat (n) frame_body.push_back(pick_link_byte());
  endtask

  task automatic send_frame(input bit spoil, input bit end_frame);
    logic [15:0] sum;
    int i;
    sum = '0;
    for (i = 0; i < frame_body.size(); i++)
      sum = crc16_update(sum, frame_body[i]);
    if (spoil)
      sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(CH_SOH);
    for (i = 0; i < frame_body.size(); i++)
      send_stuffed(frame_body[i]);
    send_stuffed(sum[7:0]);
    send_stuffed(sum[15:8]);
    if (end_frame)
      send_byte(CH_EOT);
  endtask

  task automatic test_plain_frames();
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h55);
    send_frame(1'b0, 1'b1);
    frame_body.delete();
    frame_body.push_back(8'hA5);
    send_frame(1'b1, 1'b1);
    // CRC bytes only: matches, but no payload
    frame_body.delete();
    send_frame(1'b0, 1'b1);
  endtask

  task automatic test_escaped_codes();
    frame_body.delete();
    frame_body.push_back(CH_SOH);
    frame_body.push_back(CH_EOT);
    frame_body.push_back(CH_DLE);
    send_frame(1'b0, 1'b1);
    send_byte(CH_DLE);
    send_byte(8'h7E);
    send_byte(CH_EOT);
  endtask

  task automatic test_short_frames();
    send_byte(CH_SOH);
    send_byte(CH_EOT);
    send_byte(CH_SOH);
    send_byte(8'h12);
    send_byte(CH_EOT);
    send_byte(CH_SOH);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(CH_EOT);
    // state survives EOT
    send_byte(CH_EOT);
    send_byte(CH_SOH);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(CH_SOH);
    send_byte(CH_DLE);
    send_byte(CH_EOT);
    send_byte(CH_EOT);
  endtask

  task automatic test_buffer_wrap();
    fill_random_body(BUFFER_BYTES - 5);
    send_frame(1'b0, 1'b1);
    fill_random_body(BUFFER_BYTES - 4);
    send_frame(1'b0, 1'b1);
    fill_random_body(BUFFER_BYTES);
    send_frame(1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        fill_random_body(pick_body_len());
        send_frame($urandom_range(0, 99) < 15, 1'b1);
      end else if (pick < 84) begin
        fill_random_body($urandom_range(0, 12));
        case ($urandom_range(0, 2))
          0: send_frame(1'b0, 1'b0);
          1: begin
            send_frame(1'b0, 1'b0);
            send_byte(CH_DLE);
            send_byte(CH_EOT);
          end
          default: begin
            send_frame(1'b0, 1'b1);
            send_byte(CH_EOT);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(pick_link_byte());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready = 1'b0;
    link_escape = 1'b0;
    link_count = '0;
    link_crc = '0;
    newest_rx = '0;
    older_rx = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_frames();
    test_escaped_codes();
    test_short_frames();
    test_buffer_wrap();
    test_random_traffic();

    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("sent %0d link bytes; checked %0d results: %0d payload bytes, %0d good frames,",
             bytes_sent, results_seen, payload_seen, good_seen);
    $display("%0d bad frames; %0d mismatches", bad_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("escaped_frame_receiver_crc_check regression: pass");
    end else begin
      $display("escaped_frame_receiver_crc_check regression: fail");
    end
    $finish;
  end

endmodule
